/* hw/rtl/mrpt_pkg.sv */
// ----------------------------------------------------------------------------
// mrpt_pkg: shared types and constants for the primality tester
// Witness base table and the command and status structs used between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mrpt_pkg;

  localparam int unsigned MaxBases = 12;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,  // latch n, form n-1, start d/s split
    OP_BASE   = 3'd2,  // r = 1, b = base, e = d
    OP_MUL_RB = 3'd3,  // r = r*b mod n
    OP_MUL_BB = 3'd4,  // b = b*b mod n, e >>= 1
    OP_MUL_RR = 3'd5   // r = r*r mod n
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] base_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;        // split or multiply in progress
    logic trivial;     // decided without witnesses
    logic trivial_val;
    logic base_skip;   // base > n-2
    logic e_zero;
    logic e_lsb;
    logic r_one;
    logic r_nm1;
    logic s_last;      // squarings left is one or zero
  } dp_stat_t;

  function automatic logic [5:0] witness(input logic [3:0] k);
    logic [5:0] w;
    begin
      unique case (k)
        4'd0: w = 6'd2;
        4'd1: w = 6'd3;
        4'd2: w = 6'd5;
        4'd3: w = 6'd7;
        4'd4: w = 6'd11;
        4'd5: w = 6'd13;
        4'd6: w = 6'd17;
        4'd7: w = 6'd19;
        4'd8: w = 6'd23;
        4'd9: w = 6'd29;
        4'd10: w = 6'd31;
        4'd11: w = 6'd37;
        default: w = 6'd2;
      endcase
      return w;
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/mrpt_datapath.sv */
// ----------------------------------------------------------------------------
// mrpt_datapath: operand registers and shift-and-add modular multiplier
// Holds n, d, s, the exponent and the r/b operands; one multiplier bit per
// cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mrpt_datapath #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [DATA_WIDTH-2:0]       candidate,
  input  wire mrpt_pkg::dp_cmd_t           cmd,
  output mrpt_pkg::dp_stat_t               stat
);
  import mrpt_pkg::*;

  localparam int unsigned W  = DATA_WIDTH - 1;
  localparam int unsigned CW = $clog2(W + 1);

  // product destinations
  localparam logic [1:0] DstR  = 2'd0;
  localparam logic [1:0] DstB  = 2'd1;
  localparam logic [1:0] DstSq = 2'd2;

  logic [W-1:0] n, nm1, d, e, r, b, acc, ma, mb;
  logic [CW-1:0] s_cnt, sq_cnt, bit_cnt;
  logic splitting, mul_busy;
  logic [1:0] mdst;
  logic [W:0] dbl, dbl_red, add, add_red;
  logic [W-1:0] acc_step;
  logic [W-1:0] wbase;

  assign wbase = W'(witness(cmd.base_idx));

  // one shift-and-add step of the modular product
  always_comb begin
    dbl      = {acc, 1'b0};
    dbl_red  = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
    add      = dbl_red + {1'b0, ma};
    add_red  = (add >= {1'b0, n}) ? add - {1'b0, n} : add;
    acc_step = mb[W-1] ? add_red[W-1:0] : dbl_red[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      splitting <= 1'b0;
      mul_busy  <= 1'b0;
    end else begin
      if (splitting) begin
        if (d[0]) begin
          splitting <= 1'b0;
        end else begin
          d     <= d >> 1;
          s_cnt <= s_cnt + CW'(1);
        end
      end else if (mul_busy) begin
        acc     <= acc_step;
        mb      <= mb << 1;
        bit_cnt <= bit_cnt - CW'(1);
        if (bit_cnt == CW'(1)) begin
          mul_busy <= 1'b0;
          if (mdst == DstB) b <= acc_step;
          else              r <= acc_step;
        end
      end else begin
        unique case (cmd.op)
          OP_LOAD: begin
            n         <= candidate;
            nm1       <= candidate - W'(1);
            d         <= candidate - W'(1);
            s_cnt     <= '0;
            splitting <= ~candidate[0] ? 1'b0 : (candidate > W'(3));
          end
          OP_BASE: begin
            r      <= W'(1);
            b      <= wbase;
            e      <= d;
            sq_cnt <= s_cnt;
          end
          OP_MUL_RB: begin
            ma <= r; mb <= b; acc <= '0; bit_cnt <= CW'(W);
            mdst <= DstR; mul_busy <= 1'b1;
          end
          OP_MUL_BB: begin
            ma <= b; mb <= b; acc <= '0; bit_cnt <= CW'(W);
            mdst <= DstB; mul_busy <= 1'b1; e <= e >> 1;
          end
          OP_MUL_RR: begin
            ma <= r; mb <= r; acc <= '0; bit_cnt <= CW'(W);
            mdst <= DstSq; mul_busy <= 1'b1; sq_cnt <= sq_cnt - CW'(1);
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    stat.busy        = splitting | mul_busy;
    stat.trivial     = ~n[0] | (n <= W'(3));
    stat.trivial_val = (n == W'(2)) | (n == W'(3));
    stat.base_skip   = wbase > (n - W'(2));
    stat.e_zero      = (e == '0);
    stat.e_lsb       = e[0];
    stat.r_one       = (r == W'(1));
    stat.r_nm1       = (r == nm1);
    stat.s_last      = (sq_cnt <= CW'(1));
  end

endmodule
`default_nettype wire

/* hw/rtl/mrpt_ctrl.sv */
// ----------------------------------------------------------------------------
// mrpt_ctrl: sequencer for the witness loop
// Walks the bases, drives exponentiation and squaring, and forms the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mrpt_ctrl #(
  parameter int unsigned NUM_BASES = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_go,
  input  wire logic               out_free,
  output logic                    idle,
  output logic                    done,
  output logic                    verdict,
  output mrpt_pkg::dp_cmd_t       cmd,
  input  wire mrpt_pkg::dp_stat_t stat
);
  import mrpt_pkg::*;

  localparam logic [3:0] NB = (NUM_BASES > MaxBases) ? 4'(MaxBases) : 4'(NUM_BASES);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SPLIT = 8'b0000_0010,
    S_BASE  = 8'b0000_0100,
    S_EXP   = 8'b0000_1000,
    S_SQB   = 8'b0001_0000,
    S_CHK   = 8'b0010_0000,
    S_SQR   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [3:0] k, k_next;
  logic verdict_next, wait_mul, wait_mul_next;

  always_comb begin
    state_next    = state;
    k_next        = k;
    verdict_next  = verdict;
    wait_mul_next = 1'b0;
    cmd.op        = OP_NONE;
    cmd.base_idx  = k;
    unique case (state)
      S_IDLE: if (in_go) begin
        cmd.op = OP_LOAD; state_next = S_SPLIT; k_next = '0;
      end
      S_SPLIT: if (!stat.busy) begin
        if (stat.trivial) begin
          verdict_next = stat.trivial_val; state_next = S_DONE;
        end else begin
          verdict_next = 1'b1; state_next = S_BASE;
        end
      end
      S_BASE: begin
        if (k == NB) state_next = S_DONE;
        else if (stat.base_skip) k_next = k + 4'd1;
        else begin
          cmd.op = OP_BASE; state_next = S_EXP;
        end
      end
      S_EXP: if (!stat.busy && !wait_mul) begin
        if (stat.e_zero) state_next = S_CHK;
        else if (stat.e_lsb) begin
          cmd.op = OP_MUL_RB; state_next = S_SQB; wait_mul_next = 1'b1;
        end else begin
          cmd.op = OP_MUL_BB; wait_mul_next = 1'b1;
        end
      end
      S_SQB: if (!stat.busy && !wait_mul) begin
        cmd.op = OP_MUL_BB; state_next = S_EXP; wait_mul_next = 1'b1;
      end
      S_CHK: begin
        if (stat.r_one || stat.r_nm1) begin
          k_next = k + 4'd1; state_next = S_BASE;
        end else if (stat.s_last) begin
          verdict_next = 1'b0; state_next = S_DONE;
        end else begin
          cmd.op = OP_MUL_RR; state_next = S_SQR; wait_mul_next = 1'b1;
        end
      end
      S_SQR: if (!stat.busy && !wait_mul) begin
        if (stat.r_nm1) begin
          k_next = k + 4'd1; state_next = S_BASE;
        end else if (stat.s_last) begin
          verdict_next = 1'b0; state_next = S_DONE;
        end else begin
          cmd.op = OP_MUL_RR; wait_mul_next = 1'b1;
        end
      end
      // hold the verdict until the result register can take it
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; k <= '0; verdict <= 1'b0; wait_mul <= 1'b0;
    end else begin
      state <= state_next; k <= k_next; verdict <= verdict_next;
      wait_mul <= wait_mul_next;
    end
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

endmodule
`default_nettype wire

/* hw/rtl/miller_rabin_primality_test.sv */
// ----------------------------------------------------------------------------
// miller_rabin_primality_test: deterministic Miller-Rabin, 63-bit input
// Controller plus datapath with a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | request   | in_valid, in_ready, candidate
// out     | result    | out_valid, out_ready, is_prime
// Each modular product is issued to the shared shift-and-add multiplier; a base
// takes fewer than 2*(DATA_WIDTH-1) products; a request tries up to 12 bases.
// Even inputs and inputs up to 3 are decided without any witness base.
// One request at a time; the result register frees the core, so the next
// request is taken while a result waits. Reset clears control state only.
`timescale 1ns / 1ps
`default_nettype none
module miller_rabin_primality_test #(
  parameter int unsigned NUM_BASES  = 12,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DATA_WIDTH-2:0] candidate,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       is_prime
);
  import mrpt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic idle, done, verdict, go, out_free;

  assign in_ready = idle;
  assign go       = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  mrpt_ctrl #(.NUM_BASES(NUM_BASES)) u_ctrl (
    .clk, .rst, .in_go(go), .out_free, .idle, .done, .verdict, .cmd, .stat
  );

  mrpt_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst, .candidate, .cmd, .stat
  );

  // result register; done only while it is free, since the core holds in S_DONE
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (done && out_free) begin
        out_valid <= 1'b1;
        is_prime  <= verdict;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
